@@ design/mvus_pkg.sv @@
`timescale 1ns / 1ps

package mvus_pkg;

  localparam int LANE_COUNT  = 40;
  localparam int DOT_ENGINES = 40;
  localparam int TILE_COUNT  = 7;

  // field widths of the macro-op and the micro-op
  localparam int OPC_W   = 2;
  localparam int MSIZE_W = 16;
  localparam int VSIZE_W = 10;
  localparam int MBASE_W = 16;
  localparam int TAG_W   = 8;
  localparam int ACC_W   = 16;
  localparam int VADDR_W = 11;
  localparam int BANK_W  = 2;
  localparam int MADDR_W = 17;
  localparam int FIRST_W = 25;

  localparam int PIPE_DEPTH   = (3 * LANE_COUNT) / 10;
  localparam int CHUNK_STRIDE = 3 * (LANE_COUNT / 10);
  localparam int ROW_LIMIT    = 2 * PIPE_DEPTH - 1;
  localparam int DOT_TILE     = DOT_ENGINES * TILE_COUNT;
  localparam int RUN_CAP      = 64;
  localparam int VMAX         = (1 << VSIZE_W) - 1;
  localparam int MMAX         = (1 << MSIZE_W) - 1;

  localparam int CNT_W    = $clog2(RUN_CAP);
  localparam int SLOT_W   = $clog2(2 * PIPE_DEPTH);
  localparam int SOFF_W   = $clog2((2 * PIPE_DEPTH - 2) * VMAX + 1);
  localparam int STRIDE_W = $clog2(CHUNK_STRIDE * VMAX + 1);
  localparam int FULL_W   =
    $clog2(MMAX + RUN_CAP * CHUNK_STRIDE + (2 * PIPE_DEPTH - 2) * VMAX + VMAX + MMAX + 2);
  localparam int DIV_STEPS = MSIZE_W;
  localparam int DCNT_W    = $clog2(DIV_STEPS);

  localparam logic [OPC_W-1:0] OPC_PASS = 2'd0;
  localparam logic [OPC_W-1:0] OPC_ALT  = 2'd3;

  typedef struct packed {
    logic load;
    logic div_step;
    logic step;
    logic pass;
  } mvus_cmd_t;

  typedef struct packed {
    logic pass_op;
    logic out_free;
    logic run_end;
  } mvus_stat_t;

endpackage

@@ design/mvus_in_if.sv @@
`timescale 1ns / 1ps

interface mvus_in_if;
  logic                          valid;
  logic                          ready;
  logic [mvus_pkg::OPC_W-1:0]    opcode;
  logic [mvus_pkg::MSIZE_W-1:0]  matrix_size;
  logic [mvus_pkg::VSIZE_W-1:0]  vector_size;
  logic [mvus_pkg::VSIZE_W-1:0]  vec_base_a;
  logic [mvus_pkg::VSIZE_W-1:0]  vec_base_b;
  logic [mvus_pkg::VSIZE_W-1:0]  vec_base_c;
  logic [mvus_pkg::MBASE_W-1:0]  matrix_base;
  logic [mvus_pkg::TAG_W-1:0]    op_tag;

  modport source (output valid, opcode, matrix_size, vector_size, vec_base_a, vec_base_b,
                  vec_base_c, matrix_base, op_tag, input ready);
  modport sink (input valid, opcode, matrix_size, vector_size, vec_base_a, vec_base_b,
                vec_base_c, matrix_base, op_tag, output ready);
endinterface

@@ design/mvus_out_if.sv @@
`timescale 1ns / 1ps

interface mvus_out_if;
  logic                          valid;
  logic                          ready;
  logic [mvus_pkg::OPC_W-1:0]    uop_code;
  logic                          vec_enable;
  logic [mvus_pkg::ACC_W-1:0]    accum_count;
  logic [mvus_pkg::VADDR_W-1:0]  vec_address;
  logic [mvus_pkg::BANK_W-1:0]   vec_bank;
  logic                          reg_select;
  logic [mvus_pkg::MADDR_W-1:0]  matrix_address;
  logic                          accum_done;
  logic [mvus_pkg::TAG_W-1:0]    out_tag;
  logic [mvus_pkg::FIRST_W-1:0]  first_count;
  logic                          last_mark;

  modport source (output valid, uop_code, vec_enable, accum_count, vec_address, vec_bank,
                  reg_select, matrix_address, accum_done, out_tag, first_count, last_mark,
                  input ready);
  modport sink (input valid, uop_code, vec_enable, accum_count, vec_address, vec_bank,
                reg_select, matrix_address, accum_done, out_tag, first_count, last_mark,
                output ready);
endinterface

@@ design/mvus_ctrl.sv @@
`timescale 1ns / 1ps

module mvus_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  mvus_in_if.sink              macro_op,
  input  mvus_pkg::mvus_stat_t stat,
  output mvus_pkg::mvus_cmd_t  cmd
);
  import mvus_pkg::*;

  typedef enum logic [1:0] {
    IDLE,
    DIVIDE,
    RUN,
    PASS
  } state_t;

  state_t            state;
  logic [DCNT_W-1:0] div_cnt;

  assign macro_op.ready = (state == IDLE);

  always_comb begin
    cmd          = '0;
    cmd.load     = macro_op.valid && macro_op.ready;
    cmd.div_step = (state == DIVIDE);
    cmd.step     = (state == RUN) && stat.out_free;
    cmd.pass     = (state == PASS) && stat.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= IDLE;
      div_cnt <= '0;
    end else begin
      case (state)
        IDLE: begin
          div_cnt <= '0;
          if (cmd.load) begin
            state <= stat.pass_op ? PASS : DIVIDE;
          end
        end
        DIVIDE: begin
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == DCNT_W'(DIV_STEPS - 1)) begin
            state <= RUN;
          end
        end
        RUN: begin
          if (cmd.step && stat.run_end) begin
            state <= IDLE;
          end
        end
        PASS: begin
          if (cmd.pass) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

@@ design/mvus_dp.sv @@
`timescale 1ns / 1ps

module mvus_dp (
  input  logic                 clk,
  input  logic                 rst,
  mvus_in_if.sink              macro_op,
  mvus_out_if.source           uop,
  input  mvus_pkg::mvus_cmd_t  cmd,
  output mvus_pkg::mvus_stat_t stat
);
  import mvus_pkg::*;

  // held macro-op
  logic [OPC_W-1:0]   opcode;
  logic [MSIZE_W-1:0] msize;
  logic [VSIZE_W-1:0] vsize;
  logic [VSIZE_W-1:0] base_a;
  logic [VSIZE_W-1:0] base_b;
  logic [VSIZE_W-1:0] base_c;
  logic [MBASE_W-1:0] mbase;
  logic [TAG_W-1:0]   tag;
  logic [STRIDE_W-1:0] stride;

  // divider, rows_left doubles as the quotient
  logic [VSIZE_W-1:0] rem;
  logic [MSIZE_W-1:0] rows_left;

  // walk counters
  logic [SLOT_W-1:0]  slot;
  logic [1:0]         slot_mod3;
  logic [BANK_W-1:0]  slot_div3;
  logic [VSIZE_W-1:0] word;
  logic [SOFF_W-1:0]  slot_off;
  logic [FULL_W-1:0]  chunk_off;
  logic [CNT_W-1:0]   count;
  logic               toggle;

  logic [VSIZE_W:0]   trial;
  logic               ge;
  logic [VSIZE_W-1:0] in_v;
  logic [FULL_W-1:0]  addr;
  logic [FULL_W-1:0]  addr_inc;
  logic [FULL_W-1:0]  endp;
  logic               cont;
  logic [ACC_W-1:0]   acc;
  logic               slot_more;
  logic               enable;
  logic [VSIZE_W-1:0] vbase;
  logic [FIRST_W-1:0] first_val;
  logic [FIRST_W-1:0] alt_prod;

  assign in_v  = (macro_op.vector_size == '0) ? VSIZE_W'(1) : macro_op.vector_size;
  assign trial = {rem, rows_left[MSIZE_W-1]};
  assign ge    = trial >= {1'b0, vsize};

  assign addr     = FULL_W'(mbase) + chunk_off + FULL_W'(slot_off) + FULL_W'(word);
  assign addr_inc = addr + FULL_W'(1);
  assign endp     = FULL_W'(mbase) + FULL_W'(msize);
  assign cont     = addr_inc < endp;
  assign acc      = (rows_left > ACC_W'(ROW_LIMIT)) ? ACC_W'(PIPE_DEPTH) : rows_left;
  assign slot_more = (ACC_W'(slot) + ACC_W'(1)) < acc;
  assign enable   = slot < SLOT_W'(PIPE_DEPTH);

  always_comb begin
    case (slot_mod3)
      2'd0:    vbase = base_a;
      2'd1:    vbase = base_b;
      default: vbase = base_c;
    endcase
  end

  assign alt_prod = FIRST_W'(32'(msize) * 32'(DOT_TILE));

  always_comb begin
    first_val = '0;
    if (count == '0) begin
      if (opcode == OPC_ALT) begin
        first_val = alt_prod;
      end else begin
        first_val = FIRST_W'({rows_left, 1'b0}) + FIRST_W'(rows_left);
      end
    end
  end

  assign stat.pass_op  = (macro_op.opcode == OPC_PASS);
  assign stat.out_free = !uop.valid || uop.ready;
  assign stat.run_end  = !cont || (count == CNT_W'(RUN_CAP - 1));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      opcode <= macro_op.opcode;
      msize  <= macro_op.matrix_size;
      vsize  <= in_v;
      base_a <= macro_op.vec_base_a;
      base_b <= macro_op.vec_base_b;
      base_c <= macro_op.vec_base_c;
      mbase  <= macro_op.matrix_base;
      tag    <= macro_op.op_tag;
      // stride times v, constant multiply
      stride <= STRIDE_W'(32'(in_v) * 32'(CHUNK_STRIDE));
    end
  end

  // restoring divide of matrix_size by the vector size, one bit a cycle
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem       <= '0;
      rows_left <= macro_op.matrix_size;
    end else if (cmd.div_step) begin
      rem       <= ge ? VSIZE_W'(trial - {1'b0, vsize}) : trial[VSIZE_W-1:0];
      rows_left <= {rows_left[MSIZE_W-2:0], ge};
    end else if (cmd.step && cont && !slot_more && (word + 1'b1 == vsize)
                 && (rows_left > MSIZE_W'(ROW_LIMIT))) begin
      rows_left <= rows_left - MSIZE_W'(PIPE_DEPTH);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      slot      <= '0;
      slot_mod3 <= '0;
      slot_div3 <= '0;
      word      <= '0;
      slot_off  <= '0;
      chunk_off <= '0;
      count     <= '0;
    end else if (cmd.step) begin
      count <= count + 1'b1;
      if (cont) begin
        if (slot_more) begin
          slot     <= slot + 1'b1;
          slot_off <= slot_off + SOFF_W'(vsize);
          if (slot_mod3 == 2'd2) begin
            slot_mod3 <= '0;
            slot_div3 <= slot_div3 + 1'b1;
          end else begin
            slot_mod3 <= slot_mod3 + 1'b1;
          end
        end else begin
          slot      <= '0;
          slot_mod3 <= '0;
          slot_div3 <= '0;
          slot_off  <= '0;
          if (word + 1'b1 != vsize) begin
            word <= word + 1'b1;
          end else begin
            word      <= '0;
            chunk_off <= chunk_off + FULL_W'(stride);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      toggle    <= 1'b0;
      uop.valid <= 1'b0;
    end else begin
      if (cmd.step && !(cont && slot_more)) begin
        toggle <= !toggle;
      end
      if (cmd.step || cmd.pass) begin
        uop.valid <= 1'b1;
      end else if (uop.ready) begin
        uop.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pass) begin
      uop.uop_code       <= OPC_PASS;
      uop.vec_enable     <= 1'b0;
      uop.accum_count    <= '0;
      uop.vec_address    <= '0;
      uop.vec_bank       <= '0;
      uop.reg_select     <= 1'b0;
      uop.matrix_address <= '0;
      uop.accum_done     <= 1'b0;
      uop.out_tag        <= '0;
      uop.first_count    <= '0;
      uop.last_mark      <= 1'b0;
    end else if (cmd.step) begin
      uop.uop_code       <= opcode;
      uop.vec_enable     <= enable;
      uop.accum_count    <= acc;
      uop.vec_address    <= enable ? (VADDR_W'(vbase) + VADDR_W'(word)) : '0;
      uop.vec_bank       <= enable ? slot_div3 : '0;
      uop.reg_select     <= toggle;
      uop.matrix_address <= addr[MADDR_W-1:0];
      uop.accum_done     <= (word + 1'b1 == vsize);
      uop.out_tag        <= tag;
      uop.first_count    <= first_val;
      uop.last_mark      <= (addr_inc == endp);
    end
  end

endmodule

@@ design/matrix_vector_uop_sequencer_core.sv @@
`timescale 1ns / 1ps

// Expands each matrix-vector macro-op into a run of micro-ops, one item per cycle
// while the output side takes them. An opcode of zero yields a single all-zero
// micro-op, issued from the PASS state once the output register is free. Any other
// opcode first runs a bit-serial divider (matrix_size over vector_size) and then
// emits one micro-op per cycle while the output side takes them, until the matrix
// address reaches matrix_base + matrix_size - 1, at most 64 micro-ops. A new
// macro-op is accepted once the last micro-op of the run sits in the output
// register.
module matrix_vector_uop_sequencer_core (
  input logic        clk,
  input logic        rst,
  mvus_in_if.sink    macro_op,
  mvus_out_if.source uop
);
  import mvus_pkg::*;

  mvus_cmd_t  cmd;
  mvus_stat_t stat;

  mvus_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .macro_op (macro_op),
    .stat     (stat),
    .cmd      (cmd)
  );

  mvus_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .macro_op (macro_op),
    .uop      (uop),
    .cmd      (cmd),
    .stat     (stat)
  );

  // never overwrite a micro-op still waiting at the output
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.step || cmd.pass) |-> (!uop.valid || uop.ready))
    else $error("micro-op issued over a pending output item");

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.div_step, cmd.step, cmd.pass}))
    else $error("more than one datapath command at once");

  // after taking a macro-op the block is busy in the next cycle
  a_busy_after_load: assert property (@(posedge clk) disable iff (rst)
    (macro_op.valid && macro_op.ready) |=> !macro_op.ready)
    else $error("macro-op accepted while previous one still in flight");

endmodule

@@ bench/matrix_vector_uop_sequencer_core_tb.sv @@
`timescale 1ns / 1ps

module matrix_vector_uop_sequencer_core_tb;
  import mvus_pkg::*;

  localparam logic [OPC_W-1:0] OPC_RUN1 = 2'd1;
  localparam logic [OPC_W-1:0] OPC_RUN2 = 2'd2;

  localparam int RANDOM_OPS      = 412;
  localparam int PRESSURE_AFTER  = 400;
  localparam int PRESSURE_CYCLES = 300;
  localparam int DRAIN_LIMIT     = 200000;
  localparam int SETTLE_CYCLES   = 40;

  typedef struct packed {
    logic [OPC_W-1:0]   opcode;
    logic [MSIZE_W-1:0] matrix_size;
    logic [VSIZE_W-1:0] vector_size;
    logic [VSIZE_W-1:0] vec_base_a;
    logic [VSIZE_W-1:0] vec_base_b;
    logic [VSIZE_W-1:0] vec_base_c;
    logic [MBASE_W-1:0] matrix_base;
    logic [TAG_W-1:0]   op_tag;
  } macro_op_t;

  typedef struct packed {
    logic [OPC_W-1:0]   uop_code;
    logic               vec_enable;
    logic [ACC_W-1:0]   accum_count;
    logic [VADDR_W-1:0] vec_address;
    logic [BANK_W-1:0]  vec_bank;
    logic               reg_select;
    logic [MADDR_W-1:0] matrix_address;
    logic               accum_done;
    logic [TAG_W-1:0]   out_tag;
    logic [FIRST_W-1:0] first_count;
    logic               last_mark;
  } uop_t;

  class uop_scoreboard;
    uop_t pending_uops[$];
    bit   buffer_toggle;
    int   errors;
    int   uops_checked;
    int   macro_ops;
    int   pass_ops;
    int   capped_runs;
    int   chunked_runs;
    int   empty_row_runs;

    function void field_check(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t mismatch %s: expected 0x%0h, actual 0x%0h", $time, name, want, got);
      end
    endfunction

    // expands one accepted macro-op into the micro-ops it should produce
    function void expand_macro_op(macro_op_t m);
      uop_t        u;
      int unsigned v, endp, rows, slot, word, chunk, acc, count;
      int unsigned addr, base, vaddr, bank, first;
      bit          walking;
      bit          chunked;
      macro_ops++;
      if (m.opcode == OPC_PASS) begin
        u = '0;
        pending_uops.push_back(u);
        pass_ops++;
        return;
      end
      v = (m.vector_size == '0) ? 1 : 32'(m.vector_size);
      endp = 32'(m.matrix_base) + 32'(m.matrix_size);
      rows = 32'(m.matrix_size) / v;
      if (rows == 0)
        empty_row_runs++;
      slot = 0;
      word = 0;
      chunk = 0;
      count = 0;
      walking = 1'b1;
      chunked = 1'b0;
      while (walking && count < RUN_CAP) begin
        acc = (rows > ROW_LIMIT) ? PIPE_DEPTH : rows;
        case (slot % 3)
          0: base = 32'(m.vec_base_a);
          1: base = 32'(m.vec_base_b);
          default: base = 32'(m.vec_base_c);
        endcase
        addr = 32'(m.matrix_base) + chunk * CHUNK_STRIDE * v + slot * v + word;
        vaddr = base + word;
        bank = (slot / 3) % 4;
        first = 0;
        if (slot == 0 && word == 0 && chunk == 0)
          first = (m.opcode == OPC_ALT) ? 32'(m.matrix_size) * DOT_TILE : rows * 3;
        u.uop_code       = m.opcode;
        u.vec_enable     = (slot < PIPE_DEPTH);
        u.accum_count    = acc[ACC_W-1:0];
        u.vec_address    = u.vec_enable ? vaddr[VADDR_W-1:0] : '0;
        u.vec_bank       = u.vec_enable ? bank[BANK_W-1:0] : '0;
        u.reg_select     = buffer_toggle;
        u.matrix_address = addr[MADDR_W-1:0];
        u.accum_done     = ((word + 1) % v) == 0;
        u.out_tag        = m.op_tag;
        u.first_count    = first[FIRST_W-1:0];
        u.last_mark      = (addr + 1 == endp);
        pending_uops.push_back(u);
        count++;
        if (addr + 1 < endp) begin
          if (slot + 1 < acc) begin
            slot++;
          end else begin
            buffer_toggle = ~buffer_toggle;
            slot = 0;
            if (word + 1 < v) begin
              word++;
            end else begin
              word = 0;
              if (rows > ROW_LIMIT)
                rows -= PIPE_DEPTH;
              chunk = (chunk + 1) % 65536;
              chunked = 1'b1;
            end
          end
        end else begin
          buffer_toggle = ~buffer_toggle;
          walking = 1'b0;
        end
      end
      // capped run: walk is dropped, toggle keeps its last update
      if (walking)
        capped_runs++;
      if (chunked)
        chunked_runs++;
    endfunction

    function void check_uop(uop_t got);
      uop_t want;
      if (pending_uops.size() == 0) begin
        errors++;
        $display("%0t unexpected micro-op: expected none, actual 0x%0h", $time, got);
        return;
      end
      want = pending_uops.pop_front();
      uops_checked++;
      field_check("uop_code", 32'(want.uop_code), 32'(got.uop_code));
      field_check("vec_enable", 32'(want.vec_enable), 32'(got.vec_enable));
      field_check("accum_count", 32'(want.accum_count), 32'(got.accum_count));
      field_check("vec_address", 32'(want.vec_address), 32'(got.vec_address));
      field_check("vec_bank", 32'(want.vec_bank), 32'(got.vec_bank));
      field_check("reg_select", 32'(want.reg_select), 32'(got.reg_select));
      field_check("matrix_address", 32'(want.matrix_address), 32'(got.matrix_address));
      field_check("accum_done", 32'(want.accum_done), 32'(got.accum_done));
      field_check("out_tag", 32'(want.out_tag), 32'(got.out_tag));
      field_check("first_count", 32'(want.first_count), 32'(got.first_count));
      field_check("last_mark", 32'(want.last_mark), 32'(got.last_mark));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  bit   steady_flow = 1'b0;

  uop_scoreboard uop_sb = new();

  mvus_in_if  op_bus ();
  mvus_out_if uop_bus ();

  matrix_vector_uop_sequencer_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .macro_op (op_bus),
    .uop      (uop_bus)
  );

  always #5 clk = ~clk;

  initial begin
    #40_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady_flow || r < 60)
      return 0;
    if (r < 90)
      return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  function automatic macro_op_t random_macro_op();
    macro_op_t   m;
    int unsigned r, v, rows, msize;
    r = $urandom_range(0, 99);
    if (r < 10)
      m.opcode = OPC_PASS;
    else if (r < 40)
      m.opcode = OPC_RUN1;
    else if (r < 70)
      m.opcode = OPC_RUN2;
    else
      m.opcode = OPC_ALT;
    r = $urandom_range(0, 99);
    if (r < 60)
      v = $urandom_range(1, 4);
    else if (r < 85)
      v = $urandom_range(5, 40);
    else
      v = $urandom_range(41, VMAX);
    rows = $urandom_range(1, 60);
    if (rows * v > MMAX)
      rows = MMAX / v;
    msize = rows * v;
    r = $urandom_range(0, 99);
    if (r >= 70 && r < 85) begin
      // sizes padded by one to v words, mostly not dividing evenly
      msize = msize + $urandom_range(1, v);
      if (msize > MMAX)
        msize = MMAX;
    end else if (r >= 85) begin
      msize = $urandom_range(0, MMAX);
      v = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(0, VMAX);
    end
    m.matrix_size = MSIZE_W'(msize);
    m.vector_size = VSIZE_W'(v);
    m.vec_base_a  = VSIZE_W'($urandom);
    m.vec_base_b  = VSIZE_W'($urandom);
    m.vec_base_c  = VSIZE_W'($urandom);
    r = $urandom_range(0, 9);
    if (r == 0)
      m.matrix_base = '0;
    else if (r == 1)
      m.matrix_base = MBASE_W'(MMAX - $urandom_range(0, 100));
    else
      m.matrix_base = MBASE_W'($urandom);
    m.op_tag = TAG_W'($urandom);
    return m;
  endfunction

  // offer one macro-op and hold it until the block takes it
  task automatic send_macro_op(input macro_op_t m);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      op_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    op_bus.valid       <= 1'b1;
    op_bus.opcode      <= m.opcode;
    op_bus.matrix_size <= m.matrix_size;
    op_bus.vector_size <= m.vector_size;
    op_bus.vec_base_a  <= m.vec_base_a;
    op_bus.vec_base_b  <= m.vec_base_b;
    op_bus.vec_base_c  <= m.vec_base_c;
    op_bus.matrix_base <= m.matrix_base;
    op_bus.op_tag      <= m.op_tag;
    @(posedge clk);
    while (!op_bus.ready)
      @(posedge clk);
    uop_sb.expand_macro_op(m);
  endtask

  task automatic send_fields(input logic [OPC_W-1:0] opcode, input int unsigned msize,
                             input int unsigned vsize, input int unsigned base_a,
                             input int unsigned base_b, input int unsigned base_c,
                             input int unsigned mbase, input int unsigned tag);
    macro_op_t m;
    m.opcode      = opcode;
    m.matrix_size = MSIZE_W'(msize);
    m.vector_size = VSIZE_W'(vsize);
    m.vec_base_a  = VSIZE_W'(base_a);
    m.vec_base_b  = VSIZE_W'(base_b);
    m.vec_base_c  = VSIZE_W'(base_c);
    m.matrix_base = MBASE_W'(mbase);
    m.op_tag      = TAG_W'(tag);
    send_macro_op(m);
  endtask

  always @(posedge clk) begin
    uop_t got;
    if (!rst && uop_bus.valid && uop_bus.ready) begin
      got.uop_code       = uop_bus.uop_code;
      got.vec_enable     = uop_bus.vec_enable;
      got.accum_count    = uop_bus.accum_count;
      got.vec_address    = uop_bus.vec_address;
      got.vec_bank       = uop_bus.vec_bank;
      got.reg_select     = uop_bus.reg_select;
      got.matrix_address = uop_bus.matrix_address;
      got.accum_done     = uop_bus.accum_done;
      got.out_tag        = uop_bus.out_tag;
      got.first_count    = uop_bus.first_count;
      got.last_mark      = uop_bus.last_mark;
      uop_sb.check_uop(got);
    end
  end

  initial begin : uop_receiver
    int stall;
    bit pressure_done;
    pressure_done = 1'b0;
    uop_bus.ready <= 1'b0;
    @(posedge clk);
    while (rst)
      @(posedge clk);
    forever begin
      if (!pressure_done && uop_sb.uops_checked >= PRESSURE_AFTER) begin
        // long hold-off so the block backs up into its input
        pressure_done = 1'b1;
        uop_bus.ready <= 1'b0;
        repeat (PRESSURE_CYCLES) @(posedge clk);
      end else begin
        stall = pick_gap();
        if (stall > 0) begin
          uop_bus.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      uop_bus.ready <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin : macro_op_sender
    int waited;
    op_bus.valid       <= 1'b0;
    op_bus.opcode      <= '0;
    op_bus.matrix_size <= '0;
    op_bus.vector_size <= '0;
    op_bus.vec_base_a  <= '0;
    op_bus.vec_base_b  <= '0;
    op_bus.vec_base_c  <= '0;
    op_bus.matrix_base <= '0;
    op_bus.op_tag      <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // pass-through with every field at its top and at zero
    send_fields(OPC_PASS, MMAX, VMAX, VMAX, VMAX, VMAX, MMAX, 255);
    send_fields(OPC_PASS, 0, 0, 0, 0, 0, 0, 0);
    // consistent sizes spanning several chunks
    send_fields(OPC_RUN1, 40, 1, 0, VMAX, 512, 0, 8'h5a);
    send_fields(OPC_RUN2, 64, 1, 1, 2, 3, 1000, 8'ha5);
    // every field at its top, run hits the cap
    send_fields(OPC_ALT, MMAX, VMAX, VMAX, VMAX, VMAX, MMAX, 255);
    // zero vector size acts as one
    send_fields(OPC_RUN1, 5, 0, 10, 20, 30, 7, 1);
    // fewer words than one vector: zero accumulate count; then a single word
    send_fields(OPC_RUN2, 3, 10, 100, 200, 300, 50, 2);
    send_fields(OPC_RUN1, 1, 1, 0, 0, 0, 0, 3);
    // empty matrix: walk starts past its bound
    send_fields(OPC_ALT, 0, 1, 0, 0, 0, 0, 4);
    send_fields(OPC_RUN1, 0, 5, 1, 1, 1, 200, 5);
    send_fields(OPC_RUN2, 96, 2, 341, 682, 1, 3, 6);
    send_fields(OPC_ALT, 90, 3, 0, 0, 0, 65500, 7);
    send_fields(OPC_RUN1, 23, 1, 5, 6, 7, 0, 8);
    send_fields(OPC_ALT, 24, 1, 8, 9, 10, 0, 9);
    send_fields(OPC_RUN2, 63, 5, 11, 12, 13, 14, 10);
    send_fields(OPC_RUN1, 2046, VMAX, 100, 200, 300, 100, 11);
    send_fields(OPC_PASS, 12, 3, 4, 5, 6, 7, 12);
    send_fields(OPC_ALT, MMAX, 1, 0, 0, 0, 0, 13);

    for (int i = 0; i < RANDOM_OPS; i++) begin
      steady_flow = (i >= 150 && i < 200);
      send_macro_op(random_macro_op());
    end
    steady_flow = 1'b0;
    op_bus.valid <= 1'b0;

    waited = 0;
    while (uop_sb.pending_uops.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (uop_sb.pending_uops.size() != 0) begin
      uop_sb.errors++;
      $display("%0t missing micro-ops: expected %0d more, actual none", $time,
               uop_sb.pending_uops.size());
    end

    $display("covered %0d macro-ops (%0d pass-through, %0d capped, %0d multi-chunk, %0d zero-row)",
             uop_sb.macro_ops, uop_sb.pass_ops, uop_sb.capped_runs, uop_sb.chunked_runs,
             uop_sb.empty_row_runs);
    $display("checked %0d micro-ops field by field, %0d mismatches", uop_sb.uops_checked,
             uop_sb.errors);
    if (uop_sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
